// File: rtl/swpr_pkg.sv
// Package for the sync word packet receiver: hunt states and item layout constants.
package swpr_pkg;

  // Hunt and data states of the receiver
  typedef enum logic [2:0] {
    HUNT_IDLE = 3'd0,
    HUNT_S1   = 3'd1,
    HUNT_S2   = 3'd2,
    HUNT_S3   = 3'd3,
    HUNT_DATA = 3'd4
  } hunt_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_SYNC_THIRD  = 2'd2,
    REG_SYNC_FOURTH = 2'd3
  } reg_idx_e;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ProgressW = 7;
  localparam int unsigned OffsetW   = 6;
  localparam int unsigned WordW     = 32;
  localparam int unsigned OutDataW  = 24;

  // Result item fields; tlast carries packet_done separately
  typedef struct packed {
    logic                 checksum_bad;
    logic [ByteW-1:0]     byte_value;
    logic [OffsetW-1:0]   byte_offset;
    logic                 byte_valid;
    logic [ProgressW-1:0] progress;
  } result_t;

endpackage

// File: rtl/sync_word_packet_receiver_top.sv
// Sync word packet receiver: sync hunt, byte offset tagging and word-sum checksum check.
// Output: a result item appears in the cycle after its byte is accepted (one output register).
// Throughput: one byte per cycle; the output register takes a new item while the previous
// one is being taken, so the stream only stalls when the downstream side stalls.
// Reset: async active low; hunt restarts at the first sync byte, sync registers read zero,
// position, word assembly and running sum cleared.
module sync_word_packet_receiver_top #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [swpr_pkg::OutDataW-1:0] m_axis_tdata, // [6:0] progress, [7] byte_valid,
                                      // [13:8] byte_offset, [21:14] byte_value,
                                      // [22] checksum_bad, [23] zero
  output logic        m_axis_tlast    // packet_done
);

  localparam int unsigned PosW   = $clog2(PACKET_BYTES);
  localparam int unsigned WIdxW  = PosW - 2;
  localparam int unsigned Words  = PACKET_BYTES / 4;
  localparam logic [PosW-1:0]  LastPos   = PosW'(PACKET_BYTES - 1);
  localparam logic [PosW-1:0]  FirstPos  = PosW'(4);
  localparam logic [WIdxW-1:0] WordOne   = WIdxW'(1);
  localparam logic [WIdxW-1:0] WordTwo   = WIdxW'(2);
  localparam logic [WIdxW-1:0] WordPenul = WIdxW'(Words - 2);
  localparam logic [WIdxW-1:0] WordLast  = WIdxW'(Words - 1);
  localparam logic [swpr_pkg::ProgressW-1:0] EndProgress =
    swpr_pkg::ProgressW'(PACKET_BYTES);

  // sync pattern registers
  logic [7:0] sync_first_q, sync_second_q, sync_third_q, sync_fourth_q;

  // receiver state
  swpr_pkg::hunt_e              hunt_q, hunt_d;
  logic [PosW-1:0]              pos_q, pos_d;
  logic [swpr_pkg::WordW-1:0]   word_q, word_d;
  logic [swpr_pkg::WordW-1:0]   sum_q, sum_d;

  // output register
  logic                out_valid_q;
  swpr_pkg::result_t   res_q, res_d;
  logic                last_q, last_d;

  logic                in_accept;
  logic [7:0]          rx_byte;
  logic [PosW:0]       pos_inc;
  logic [WIdxW-1:0]    word_idx;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = {1'b0, pos_q} + {{PosW{1'b0}}, 1'b1};
  assign word_idx      = pos_q[PosW-1:2];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
      sync_third_q  <= '0;
      sync_fourth_q <= '0;
    end else if (cfg_we_i) begin
      unique case (swpr_pkg::reg_idx_e'(cfg_idx_i))
        swpr_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        swpr_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        swpr_pkg::REG_SYNC_THIRD:  sync_third_q  <= cfg_data_i;
        swpr_pkg::REG_SYNC_FOURTH: sync_fourth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and result for one byte
  always_comb begin
    hunt_d = hunt_q;
    pos_d  = pos_q;
    word_d = word_q;
    sum_d  = sum_q;
    res_d  = '0;
    last_d = 1'b0;
    unique case (hunt_q)
      swpr_pkg::HUNT_IDLE: begin
        if (rx_byte == sync_first_q) begin
          hunt_d         = swpr_pkg::HUNT_S1;
          res_d.progress = 7'd1;
        end
      end
      swpr_pkg::HUNT_S1: begin
        if (rx_byte == sync_second_q) begin
          hunt_d         = swpr_pkg::HUNT_S2;
          res_d.progress = 7'd2;
        end else if (rx_byte == sync_first_q) begin
          hunt_d         = swpr_pkg::HUNT_S1;
          res_d.progress = 7'd1;
        end else begin
          hunt_d = swpr_pkg::HUNT_IDLE;
        end
      end
      swpr_pkg::HUNT_S2: begin
        if (rx_byte == sync_third_q) begin
          hunt_d         = swpr_pkg::HUNT_S3;
          res_d.progress = 7'd3;
        end else if (rx_byte == sync_first_q) begin
          hunt_d         = swpr_pkg::HUNT_S1;
          res_d.progress = 7'd1;
        end else begin
          hunt_d = swpr_pkg::HUNT_IDLE;
        end
      end
      swpr_pkg::HUNT_S3: begin
        if (rx_byte == sync_fourth_q) begin
          hunt_d         = swpr_pkg::HUNT_DATA;
          pos_d          = FirstPos;
          word_d         = '0;
          sum_d          = '0;
          res_d.progress = 7'd4;
        end else if (rx_byte == sync_first_q) begin
          // restart at stage one, but progress still reads zero
          hunt_d = swpr_pkg::HUNT_S1;
        end else begin
          hunt_d = swpr_pkg::HUNT_IDLE;
        end
      end
      swpr_pkg::HUNT_DATA: begin
        // little-endian word assembly, one byte in at the top
        word_d = {rx_byte, word_q[31:8]};
        if (pos_q[1:0] == 2'b11) begin
          if (word_idx == WordOne) begin
            sum_d = 32'd0 - word_d;
          end else if (word_idx >= WordTwo && word_idx <= WordPenul) begin
            sum_d = sum_q + word_d;
          end else if (word_idx == WordLast) begin
            sum_d = sum_q - word_d;
          end
        end
        res_d.byte_valid  = 1'b1;
        res_d.byte_offset = swpr_pkg::OffsetW'(pos_q);
        res_d.byte_value  = rx_byte;
        if (pos_q == LastPos) begin
          hunt_d             = swpr_pkg::HUNT_IDLE;
          res_d.progress     = EndProgress;
          res_d.checksum_bad = (sum_d != 32'd0);
          last_d             = 1'b1;
        end else begin
          pos_d          = PosW'(pos_inc);
          res_d.progress = swpr_pkg::ProgressW'(pos_inc);
        end
      end
      default: begin
        hunt_d = swpr_pkg::HUNT_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q <= swpr_pkg::HUNT_IDLE;
      pos_q  <= '0;
      word_q <= '0;
      sum_q  <= '0;
    end else if (in_accept) begin
      hunt_q <= hunt_d;
      pos_q  <= pos_d;
      word_q <= word_d;
      sum_q  <= sum_d;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q  <= res_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};
  assign m_axis_tlast  = last_q;

  // In the data state the position stays inside the payload area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hunt_q == swpr_pkg::HUNT_DATA |-> (pos_q >= FirstPos && pos_q <= LastPos))
    else $error("byte position out of payload range");

  // The last byte of a packet sends the hunt back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && hunt_q == swpr_pkg::HUNT_DATA && pos_q == LastPos)
      |=> hunt_q == swpr_pkg::HUNT_IDLE)
    else $error("hunt did not restart after packet end");

  // Packet end and checksum flag only come with a stored byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.byte_valid) |-> (!last_q && !res_q.checksum_bad))
    else $error("packet end flagged without a stored byte");

  // A packet end result carries the last offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> res_q.byte_offset == swpr_pkg::OffsetW'(LastPos))
    else $error("packet end at wrong offset");

endmodule

// File: verif/tb.sv
// Testbench for the sync word packet receiver: sync hunt, packet deframing and checksum.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PktBytes = 64;
  localparam int unsigned NumWords = PktBytes / 4;

  // Expected result: packet_done travels on tlast, the rest in tdata
  typedef struct packed {
    logic              done;
    swpr_pkg::result_t res;
  } deframed_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [6:0] progress, [7] byte_valid, [13:8] byte_offset,
                               // [21:14] byte_value, [22] checksum_bad, [23] zero
  logic        m_axis_tlast;   // packet_done

  // Predicted receiver state and sync registers
  logic [7:0]      sync_pat [4];
  swpr_pkg::hunt_e hunt_stage;
  int unsigned     byte_pos;
  logic [31:0]     word_acc;
  logic [31:0]     word_sum;

  deframed_t   deframed_q [$];
  int unsigned bytes_sent;
  int unsigned errors;
  bit          tx_idle_on;
  bit          rx_idle_on;

  sync_word_packet_receiver_top #(.PACKET_BYTES(PktBytes)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // Predict the result of one received byte and advance the receiver state
  function automatic deframed_t deframe_byte(input logic [7:0] b);
    deframed_t   r;
    int unsigned w_idx;
    r = '0;
    case (hunt_stage)
      swpr_pkg::HUNT_IDLE: begin
        if (b == sync_pat[swpr_pkg::REG_SYNC_FIRST]) begin
          hunt_stage = swpr_pkg::HUNT_S1;
          r.res.progress = 7'd1;
        end
      end
      swpr_pkg::HUNT_S1: begin
        if (b == sync_pat[swpr_pkg::REG_SYNC_SECOND]) begin
          hunt_stage = swpr_pkg::HUNT_S2;
          r.res.progress = 7'd2;
        end else if (b == sync_pat[swpr_pkg::REG_SYNC_FIRST]) begin
          hunt_stage = swpr_pkg::HUNT_S1;
          r.res.progress = 7'd1;
        end else begin
          hunt_stage = swpr_pkg::HUNT_IDLE;
        end
      end
      swpr_pkg::HUNT_S2: begin
        if (b == sync_pat[swpr_pkg::REG_SYNC_THIRD]) begin
          hunt_stage = swpr_pkg::HUNT_S3;
          r.res.progress = 7'd3;
        end else if (b == sync_pat[swpr_pkg::REG_SYNC_FIRST]) begin
          hunt_stage = swpr_pkg::HUNT_S1;
          r.res.progress = 7'd1;
        end else begin
          hunt_stage = swpr_pkg::HUNT_IDLE;
        end
      end
      swpr_pkg::HUNT_S3: begin
        if (b == sync_pat[swpr_pkg::REG_SYNC_FOURTH]) begin
          hunt_stage = swpr_pkg::HUNT_DATA;
          byte_pos = 4;
          word_acc = '0;
          word_sum = '0;
          r.res.progress = 7'd4;
        end else begin
          // a restart byte re-arms the hunt but progress still reads zero
          hunt_stage = (b == sync_pat[swpr_pkg::REG_SYNC_FIRST]) ? swpr_pkg::HUNT_S1
                                                                 : swpr_pkg::HUNT_IDLE;
        end
      end
      swpr_pkg::HUNT_DATA: begin
        word_acc = {b, word_acc[31:8]};
        if (byte_pos[1:0] == 2'b11) begin
          w_idx = byte_pos >> 2;
          if (w_idx == 1) word_sum = 32'd0 - word_acc;
          else if (w_idx >= 2 && w_idx + 2 <= NumWords) word_sum = word_sum + word_acc;
          else if (w_idx + 1 == NumWords) word_sum = word_sum - word_acc;
        end
        r.res.byte_valid  = 1'b1;
        r.res.byte_offset = byte_pos[5:0];
        r.res.byte_value  = b;
        if (byte_pos + 1 >= PktBytes) begin
          hunt_stage = swpr_pkg::HUNT_IDLE;
          r.res.progress = 7'(PktBytes);
          r.res.checksum_bad = (word_sum != 0);
          r.done = 1'b1;
        end else begin
          byte_pos++;
          r.res.progress = 7'(byte_pos);
        end
      end
      default: hunt_stage = swpr_pkg::HUNT_IDLE;
    endcase
    return r;
  endfunction

  // Send one byte; tvalid stays high after acceptance so items can go back to back
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframed_q.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // Stop sending and let every pending result come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_sync(input logic [7:0] b0, b1, b2, b3);
    logic [7:0] vals [4];
    vals = '{b0, b1, b2, b3};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= swpr_pkg::reg_idx_e'(i);
      cfg_data_i <= vals[i];
      sync_pat[i] = vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Push the receiver back to hunting with bytes that match no sync byte
  task automatic align_to_hunt();
    logic [7:0] b;
    while (hunt_stage != swpr_pkg::HUNT_IDLE) begin
      do b = 8'($urandom);
      while (b == sync_pat[swpr_pkg::REG_SYNC_FIRST] || b == sync_pat[swpr_pkg::REG_SYNC_SECOND] ||
             b == sync_pat[swpr_pkg::REG_SYNC_THIRD] || b == sync_pat[swpr_pkg::REG_SYNC_FOURTH]);
      send_byte(b);
    end
  endtask

  // Full packet: sync, payload words, checksum word (optionally with one bit flipped)
  task automatic send_packet(input bit corrupt);
    logic [31:0] words [NumWords];
    logic [31:0] chk;
    int unsigned pick;
    chk = '0;
    for (int w = 1; w < NumWords - 1; w++) begin
      pick = $urandom_range(0, 7);
      words[w] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      chk = (w == 1) ? 32'd0 - words[w] : chk + words[w];
    end
    words[NumWords-1] = corrupt ? chk ^ (32'h1 << $urandom_range(0, 31)) : chk;
    align_to_hunt();
    for (int i = 0; i < 4; i++) send_byte(sync_pat[i]);
    for (int w = 1; w < NumWords; w++)
      for (int k = 0; k < 4; k++) send_byte(words[w][8*k +: 8]);
  endtask

  // Mostly well-formed packets, some broken sync runs and some noise
  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned k;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_packet(1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        align_to_hunt();
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) send_byte(sync_pat[i]);
        send_byte($urandom_range(0, 1) ? sync_pat[swpr_pkg::REG_SYNC_FIRST] : 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
    end
  endtask

  // Sync registers read zero after reset
  task automatic test_reset_defaults();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Hunt transitions short of a full sync, restart bytes and the fourth-byte mismatch
  task automatic test_hunt_cases();
    logic [7:0] seq [16];
    seq = '{8'hFF, 8'hA5, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h00, 8'hA5,
            8'h12, 8'hA5, 8'h5A, 8'hC3, 8'hA5, 8'h5A, 8'hC3, 8'h00};
    set_sync(8'hA5, 8'h5A, 8'hC3, 8'h3C);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // One packet with a good checksum, one with a bad one
  task automatic test_checksum_packets();
    send_packet(1'b0);
    send_packet(1'b1);
  endtask

  // Random traffic under several sync settings, extremes included
  task automatic test_sync_settings();
    run_traffic(160);
    set_sync(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_traffic(160);
    set_sync(8'h00, 8'h00, 8'h00, 8'h00);
    run_traffic(160);
    set_sync(8'h7E, 8'h7E, 8'h81, 8'h7E);
    run_traffic(160);
    repeat (2) begin
      set_sync(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_traffic(160);
    end
  endtask

  // Result side: random stall before each item
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic check_field(input string what, input int unsigned want_v, got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    deframed_t         want;
    swpr_pkg::result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(swpr_pkg::result_t)-1:0];
      if (deframed_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = deframed_q.pop_front();
        check_field("progress", 32'(want.res.progress), 32'(got.progress));
        check_field("byte_valid", 32'(want.res.byte_valid), 32'(got.byte_valid));
        check_field("byte_offset", 32'(want.res.byte_offset), 32'(got.byte_offset));
        check_field("byte_value", 32'(want.res.byte_value), 32'(got.byte_value));
        check_field("checksum_bad", 32'(want.res.checksum_bad), 32'(got.checksum_bad));
        check_field("packet_done", 32'(want.done), 32'(m_axis_tlast));
        check_field("pad bit", 32'd0, 32'(m_axis_tdata[23]));
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = swpr_pkg::REG_SYNC_FIRST;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sync_pat      = '{default: 8'h00};
    hunt_stage    = swpr_pkg::HUNT_IDLE;
    byte_pos      = 0;
    word_acc      = '0;
    word_sum      = '0;
    bytes_sent    = 0;
    errors        = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_hunt_cases();
    test_checksum_packets();
    test_sync_settings();

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
